FILE: hw/rtl/refractory_spike_generator_defines.svh
// Assertion macros for the checker file (rsg_checker.sv).
`ifndef REFRACTORY_SPIKE_GENERATOR_DEFINES_SVH
`define REFRACTORY_SPIKE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/rsg_pkg.sv
`timescale 1ns / 1ps
package rsg_pkg;

	localparam int NUM_FIBERS = 1024;
	localparam int FIBER_W    = $clog2(NUM_FIBERS);
	localparam int FRAC_BITS  = 16;
	localparam int REC_W      = FRAC_BITS + 1;          // Q1.FRAC_BITS, 0..ONE
	localparam int THR_W      = 2 * REC_W - FRAC_BITS;  // rate*rec >> FRAC_BITS
	localparam int RATE_W     = 16;
	localparam int KIND_W     = 2;
	localparam int TIME_W     = 32;
	localparam int SAMPLE_W   = 16;
	localparam int PRM_W      = KIND_W + RATE_W;

	localparam int IN_FIELDS_W = FIBER_W + KIND_W + RATE_W + TIME_W + SAMPLE_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = FIBER_W + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [REC_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_BACKGROUND = 2'd0,
		KIND_TONIC      = 2'd1,
		KIND_PHASIC     = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECOVERY_RATE     = 3'd0,
		REG_STIM_START_STEP   = 3'd1,
		REG_TONIC_END_STEP    = 3'd2,
		REG_PHASIC_END_STEP   = 3'd3,
		REG_TONIC_EXTRA_RATE  = 3'd4,
		REG_PHASIC_EXTRA_RATE = 3'd5
	} cfg_reg_t;

endpackage

FILE: hw/rtl/rsg_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
module rsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/refractory_spike_generator.sv
`timescale 1ns / 1ps
// Per-fiber stochastic spike generator with refractory recovery. A load
// transfer (tuser op = 0) stores a fiber's kind and background rate and sets
// its recovery level to 1.0; it returns nothing. A step transfer (op = 1)
// raises the fiber's recovery level toward 1.0 by recovery_rate of the gap,
// adds the tonic or phasic stimulus rate when step_time lies in that kind's
// window (rate saturates at 1.0), and fires when random_sample is below
// rate * recovery; firing clears the recovery level. Each step returns one
// transfer with the fiber index and the spike bit. Rates and samples are
// Q0.16; the recovery level is Q1.16. Rate: one transfer per cycle while
// tready is high; the result passes four pipeline stages, then the output
// register. The recovery memory is read on input and written back from the
// last stage, so a transfer whose fiber matches one in the four pipeline
// stages is held off (tready low) until that one has written back, longer
// if the result side stalls it. Fiber tables are undefined until a fiber is
// loaded; there is no clearing pass, and stepping a fiber never loaded
// returns an arbitrary spike bit. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module refractory_spike_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [rsg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsg_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: fiber[9:0], fiber_kind[11:10], base_rate[27:12],
	//        step_time[59:28], random_sample[75:60], zero pad[79:76]
	input  logic [rsg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [0:0]                      s_axis_tuser,  // op[0]
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: fiber_out[9:0], spike[10], zero pad[15:11]
	output logic [rsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import rsg_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [RATE_W-1:0] recovery_rate_q;
	logic [TIME_W-1:0] stim_start_q;
	logic [TIME_W-1:0] tonic_end_q;
	logic [TIME_W-1:0] phasic_end_q;
	logic [RATE_W-1:0] tonic_extra_q;
	logic [RATE_W-1:0] phasic_extra_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recovery_rate_q <= '0;
			stim_start_q    <= '0;
			tonic_end_q     <= '0;
			phasic_end_q    <= '0;
			tonic_extra_q   <= '0;
			phasic_extra_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RECOVERY_RATE:     recovery_rate_q <= cfg_data[RATE_W-1:0];
				REG_STIM_START_STEP:   stim_start_q    <= cfg_data[TIME_W-1:0];
				REG_TONIC_END_STEP:    tonic_end_q     <= cfg_data[TIME_W-1:0];
				REG_PHASIC_END_STEP:   phasic_end_q    <= cfg_data[TIME_W-1:0];
				REG_TONIC_EXTRA_RATE:  tonic_extra_q   <= cfg_data[RATE_W-1:0];
				REG_PHASIC_EXTRA_RATE: phasic_extra_q  <= cfg_data[RATE_W-1:0];
				default: ;  // indexes past the list are ignored
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input unpack
	// ------------------------------------------------------------------
	localparam int KIND_LSB   = FIBER_W;
	localparam int RATE_LSB   = KIND_LSB + KIND_W;
	localparam int TIME_LSB   = RATE_LSB + RATE_W;
	localparam int SAMPLE_LSB = TIME_LSB + TIME_W;

	op_t                 in_op;
	logic [FIBER_W-1:0]  in_fiber;
	logic [KIND_W-1:0]   in_kind;
	logic [RATE_W-1:0]   in_base;
	logic [TIME_W-1:0]   in_time;
	logic [SAMPLE_W-1:0] in_sample;
	logic                in_tonic_win;
	logic                in_phasic_win;

	assign in_op     = op_t'(s_axis_tuser[0]);
	assign in_fiber  = s_axis_tdata[FIBER_W-1:0];
	assign in_kind   = s_axis_tdata[KIND_LSB +: KIND_W];
	assign in_base   = s_axis_tdata[RATE_LSB +: RATE_W];
	assign in_time   = s_axis_tdata[TIME_LSB +: TIME_W];
	assign in_sample = s_axis_tdata[SAMPLE_LSB +: SAMPLE_W];

	// window tests done up front so stage 1 only selects
	assign in_tonic_win  = (in_time >= stim_start_q) && (in_time < tonic_end_q);
	assign in_phasic_win = (in_time >= stim_start_q) && (in_time < phasic_end_q);

	// ------------------------------------------------------------------
	// Pipeline registers
	// ------------------------------------------------------------------
	logic                v_s1, v_s2, v_s3, v_s4;
	op_t                 op_s1, op_s2, op_s3, op_s4;
	logic [FIBER_W-1:0]  fiber_s1, fiber_s2, fiber_s3, fiber_s4;
	logic [KIND_W-1:0]   ld_kind_s1, ld_kind_s2, ld_kind_s3, ld_kind_s4;
	logic [RATE_W-1:0]   ld_rate_s1, ld_rate_s2, ld_rate_s3, ld_rate_s4;
	logic [SAMPLE_W-1:0] sample_s1, sample_s2, sample_s3, sample_s4;
	logic                tonic_win_s1, phasic_win_s1;
	logic [REC_W-1:0]    rec_s2, rec_s3, rec_s4;
	logic [REC_W+RATE_W-1:0] prod_s2;
	logic [REC_W-1:0]    rate_s2, rate_s3;
	logic [THR_W-1:0]    thr_s4;

	logic                out_v_q;
	logic [FIBER_W-1:0]  out_fiber_q;
	logic                out_spike_q;

	// Per-stage advance: a stage moves when empty or when the next one moves.
	// Loads leave stage 4 without touching the output register.
	logic en1, en2, en3, en4;
	logic hazard;
	logic accept;

	assign en4 = !v_s4 || (op_s4 == OP_LOAD) || !out_v_q || m_axis_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	// Same fiber in flight: hold off until its write-back is done.
	assign hazard = (v_s1 && (fiber_s1 == in_fiber)) ||
	                (v_s2 && (fiber_s2 == in_fiber)) ||
	                (v_s3 && (fiber_s3 == in_fiber)) ||
	                (v_s4 && (fiber_s4 == in_fiber));

	assign s_axis_tready = en1 && !hazard;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------
	// Fiber tables
	// ------------------------------------------------------------------
	logic               fiber_ok_s4;
	logic               fire_s4;
	logic               tbl_we;
	logic               prm_we;
	logic [PRM_W-1:0]   prm_rd;
	logic [REC_W-1:0]   rec_rd;
	logic [REC_W-1:0]   rec_wdata;

	assign fiber_ok_s4 = ({1'b0, fiber_s4} < (FIBER_W + 1)'(NUM_FIBERS));
	assign tbl_we      = v_s4 && en4 && fiber_ok_s4;
	assign prm_we      = tbl_we && (op_s4 == OP_LOAD);
	assign rec_wdata   = (op_s4 == OP_LOAD) ? ONE : (fire_s4 ? '0 : rec_s4);

	rsg_ram #(
		.WIDTH (PRM_W),
		.DEPTH (NUM_FIBERS)
	) u_prm_ram (
		.clk   (clk),
		.we    (prm_we),
		.waddr (fiber_s4),
		.wdata ({ld_kind_s4, ld_rate_s4}),
		.re    (accept),
		.raddr (in_fiber),
		.rdata (prm_rd)
	);

	rsg_ram #(
		.WIDTH (REC_W),
		.DEPTH (NUM_FIBERS)
	) u_rec_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (fiber_s4),
		.wdata (rec_wdata),
		.re    (accept),
		.raddr (in_fiber),
		.rdata (rec_rd)
	);

	// ------------------------------------------------------------------
	// Stage 1: table data arrives; recovery gap product, rate sum
	// ------------------------------------------------------------------
	kind_t             kind_s1;
	logic [RATE_W-1:0] base_s1;
	logic [RATE_W-1:0] extra_s1;
	logic [REC_W-1:0]  rate_sum_s1;
	logic [REC_W-1:0]  rec_clip_s1;
	logic [REC_W-1:0]  gap_s1;

	assign kind_s1 = kind_t'(prm_rd[PRM_W-1 -: KIND_W]);
	assign base_s1 = prm_rd[RATE_W-1:0];

	always_comb begin
		case (kind_s1)
			KIND_TONIC:  extra_s1 = tonic_win_s1  ? tonic_extra_q  : '0;
			KIND_PHASIC: extra_s1 = phasic_win_s1 ? phasic_extra_q : '0;
			default:     extra_s1 = '0;  // background and unused code
		endcase
	end

	assign rate_sum_s1 = REC_W'(base_s1) + REC_W'(extra_s1);
	assign rec_clip_s1 = (rec_rd > ONE) ? ONE : rec_rd;
	assign gap_s1      = ONE - rec_clip_s1;

	// ------------------------------------------------------------------
	// Stage 2: recovered level
	// ------------------------------------------------------------------
	logic [REC_W:0]   rec_sum_s2;
	logic [REC_W-1:0] rec_new_s2;

	assign rec_sum_s2 = {1'b0, rec_s2} + {1'b0, prod_s2[FRAC_BITS +: REC_W]};
	assign rec_new_s2 = (rec_sum_s2 > {1'b0, ONE}) ? ONE : rec_sum_s2[REC_W-1:0];

	// ------------------------------------------------------------------
	// Stage 3: threshold product
	// ------------------------------------------------------------------
	logic [2*REC_W-1:0] thr_prod_s3;

	assign thr_prod_s3 = rate_s3 * rec_s3;

	// ------------------------------------------------------------------
	// Stage 4: compare against the sample
	// ------------------------------------------------------------------
	assign fire_s4 = (op_s4 == OP_STEP) && fiber_ok_s4 &&
	                 (THR_W'(sample_s4) < thr_s4);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1         <= in_op;
			fiber_s1      <= in_fiber;
			ld_kind_s1    <= in_kind;
			ld_rate_s1    <= in_base;
			sample_s1     <= in_sample;
			tonic_win_s1  <= in_tonic_win;
			phasic_win_s1 <= in_phasic_win;
		end
		if (en2) begin
			op_s2      <= op_s1;
			fiber_s2   <= fiber_s1;
			ld_kind_s2 <= ld_kind_s1;
			ld_rate_s2 <= ld_rate_s1;
			sample_s2  <= sample_s1;
			rec_s2     <= rec_clip_s1;
			prod_s2    <= gap_s1 * recovery_rate_q;
			rate_s2    <= (rate_sum_s1 > ONE) ? ONE : rate_sum_s1;
		end
		if (en3) begin
			op_s3      <= op_s2;
			fiber_s3   <= fiber_s2;
			ld_kind_s3 <= ld_kind_s2;
			ld_rate_s3 <= ld_rate_s2;
			sample_s3  <= sample_s2;
			rec_s3     <= rec_new_s2;
			rate_s3    <= rate_s2;
		end
		if (en4) begin
			op_s4      <= op_s3;
			fiber_s4   <= fiber_s3;
			ld_kind_s4 <= ld_kind_s3;
			ld_rate_s4 <= ld_rate_s3;
			sample_s4  <= sample_s3;
			rec_s4     <= rec_s3;
			thr_s4     <= thr_prod_s3[FRAC_BITS +: THR_W];
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic out_load;

	assign out_load = v_s4 && en4 && (op_s4 == OP_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fiber_q <= fiber_s4;
			out_spike_q <= fire_s4;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_spike_q, out_fiber_q});

endmodule

FILE: hw/rtl/rsg_checker.sv
`timescale 1ns / 1ps
`include "refractory_spike_generator_defines.svh"
module rsg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [rsg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [0:0]                      s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [rsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import rsg_pkg::*;

	logic                                in_xfer;
	logic [FIBER_W-1:0]                  in_fiber;
	logic                                out_stall;
	logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] out_pad;

	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign in_fiber  = s_axis_tdata[FIBER_W-1:0];
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_pad   = m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W];

	// stalled result holds
	`RSG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

	// result padding bits stay zero
	`RSG_ASSERT_IMPL(a_out_pad, clk, arst_n, m_axis_tvalid, out_pad == '0)

	// a fiber just taken in cannot be taken again next cycle (write-back pending)
	`RSG_ASSERT_NEXT(a_same_fiber_held, clk, arst_n, in_xfer, !(in_xfer && in_fiber == $past(in_fiber)))

	// the tuser op bit is known (not X or Z) on every input transfer
	`RSG_ASSERT_IMPL(a_tuser_known, clk, arst_n, in_xfer, !$isunknown(s_axis_tuser))

endmodule

bind refractory_spike_generator rsg_checker u_rsg_checker (.*);
